FILE: hw/rtl/pfd_pkg.sv
// Shared types, constants and helpers for the payload frame decoder.
package pfd_pkg;

  // Frame layout
  localparam int HEADER_BYTES = 12;
  localparam int VALUE_BYTES  = 8;

  // Command queue depth between front and back
  localparam int QUEUE_DEPTH = 2;

  // Output tdata: value_bits, error_code, sample_count, value_count, zero pad
  localparam int OUT_PAYLOAD_W = 64 + 2 + 32 + 32;
  localparam int OUT_TDATA_W   = ((OUT_PAYLOAD_W + 7) / 8) * 8;

  // Verdict codes
  localparam logic [1:0] ERR_OK        = 2'd0;
  localparam logic [1:0] ERR_BAD_MAGIC = 2'd1;
  localparam logic [1:0] ERR_SHORT_HDR = 2'd2;
  localparam logic [1:0] ERR_LENGTH    = 2'd3;

  // Request handed from the front to the back
  typedef struct packed {
    logic [7:0]  data;       // frame byte
    logic        last;       // final byte of the frame
    logic        assemble;   // payload byte to be shifted into the value
    logic        hdr_done;   // header complete after this byte
    logic        magic_bad;  // magic mismatch seen, including this byte
    logic [31:0] sample_cnt; // header sample count
    logic [31:0] value_cnt;  // header value count
  } cmd_t;

  // Expected magic byte at header position 0..3 ("WFL1")
  function automatic logic [7:0] magic_byte(input logic [1:0] idx);
    logic [7:0] b;
    case (idx)
      2'd0:    b = 8'h57;
      2'd1:    b = 8'h46;
      2'd2:    b = 8'h4C;
      default: b = 8'h31;
    endcase
    return b;
  endfunction

endpackage

FILE: hw/rtl/payload_frame_decoder.sv
// Top level of the payload frame decoder: front end, request queue, back end.
// A byte yielding a result goes through the request queue and output register to out_tvalid.
// Throughput: one byte per cycle while the output is not stalled; the two-entry request queue
// and output register let the front take bytes while a result waits, until the queue fills.
// Header bytes and bytes after a bad magic, except a frame's last byte, stay in the front end.
// Reset (rst_n low, synchronous) empties the queue and returns both ends to frame start.
module payload_frame_decoder
  import pfd_pkg::*;
#(
  parameter int QDEPTH = QUEUE_DEPTH
) (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   in_tvalid,
  output logic                   in_tready,
  input  logic [7:0]             in_tdata,   // [7:0] data_byte
  input  logic                   in_tlast,   // last_byte
  output logic                   out_tvalid,
  input  logic                   out_tready,
  output logic [OUT_TDATA_W-1:0] out_tdata,  // [63:0] value_bits, [65:64] error_code,
                                             // [97:66] sample_count, [129:98] value_count
  output logic                   out_tuser,  // value_valid
  output logic                   out_tlast   // frame_end
);

  logic accept;
  logic push, q_full, q_pop, q_valid;
  cmd_t push_cmd, pop_cmd;

  assign in_tready = !q_full;
  assign accept    = in_tvalid && in_tready;

  pfd_front u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .accept    (accept),
    .data_byte (in_tdata),
    .last_byte (in_tlast),
    .push      (push),
    .push_cmd  (push_cmd)
  );

  pfd_cmd_fifo #(
    .DEPTH (QDEPTH)
  ) u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (push),
    .push_cmd  (push_cmd),
    .full      (q_full),
    .pop       (q_pop),
    .pop_cmd   (pop_cmd),
    .not_empty (q_valid)
  );

  pfd_back u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .cmd_valid  (q_valid),
    .cmd        (pop_cmd),
    .cmd_pop    (q_pop),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .out_tlast  (out_tlast)
  );

endmodule

FILE: hw/rtl/pfd_front.sv
// Front end: header parsing, magic check and classification of frame bytes.
module pfd_front
  import pfd_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  input  logic       accept,
  input  logic [7:0] data_byte,
  input  logic       last_byte,
  output logic       push,
  output cmd_t       push_cmd
);

  localparam logic [3:0] HDR_LAST_POS = 4'(HEADER_BYTES - 1);

  logic [3:0]  pos_r, pos_nxt;
  logic        in_payload_r, in_payload_nxt;
  logic        magic_bad_r, magic_bad_nxt;
  logic [31:0] count_r, count_nxt;
  logic [31:0] dim_r, dim_nxt;

  // Header walk for the current byte
  always_comb begin
    pos_nxt        = pos_r;
    in_payload_nxt = in_payload_r;
    magic_bad_nxt  = magic_bad_r;
    count_nxt      = count_r;
    dim_nxt        = dim_r;
    if (!in_payload_r) begin
      if (pos_r[3:2] == 2'b00) begin
        if (data_byte != magic_byte(pos_r[1:0])) begin
          magic_bad_nxt = 1'b1;
        end
      end else if (pos_r[3:2] == 2'b01) begin
        count_nxt = {count_r[23:0], data_byte};
      end else begin
        dim_nxt = {dim_r[23:0], data_byte};
      end
      if (pos_r == HDR_LAST_POS) begin
        in_payload_nxt = 1'b1;
        pos_nxt        = '0;
      end else begin
        pos_nxt = pos_r + 4'd1;
      end
    end
  end

  // Only payload bytes to assemble and final bytes go to the back end
  assign push = accept && (last_byte || (in_payload_r && !magic_bad_r));

  always_comb begin
    push_cmd.data       = data_byte;
    push_cmd.last       = last_byte;
    push_cmd.assemble   = in_payload_r && !magic_bad_r;
    push_cmd.hdr_done   = in_payload_nxt;
    push_cmd.magic_bad  = magic_bad_nxt;
    push_cmd.sample_cnt = count_nxt;
    push_cmd.value_cnt  = dim_nxt;
  end

  // Control state, back to the start of a frame after the last byte
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pos_r        <= '0;
      in_payload_r <= 1'b0;
      magic_bad_r  <= 1'b0;
    end else if (accept) begin
      if (last_byte) begin
        pos_r        <= '0;
        in_payload_r <= 1'b0;
        magic_bad_r  <= 1'b0;
      end else begin
        pos_r        <= pos_nxt;
        in_payload_r <= in_payload_nxt;
        magic_bad_r  <= magic_bad_nxt;
      end
    end
  end

  // Header words are fully overwritten by four shifts in each frame with a complete header
  always_ff @(posedge clk) begin
    if (accept) begin
      count_r <= count_nxt;
      dim_r   <= dim_nxt;
    end
  end

endmodule

FILE: hw/rtl/pfd_cmd_fifo.sv
// Short request queue between the front and back ends.
module pfd_cmd_fifo
  import pfd_pkg::*;
#(
  parameter int DEPTH = QUEUE_DEPTH
) (
  input  logic clk,
  input  logic rst_n,
  input  logic push,
  input  cmd_t push_cmd,
  output logic full,
  input  logic pop,
  output cmd_t pop_cmd,
  output logic not_empty
);

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);
  localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(DEPTH - 1);
  localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(DEPTH);

  cmd_t             slot_r [DEPTH];
  logic [PTR_W-1:0] wr_ptr_r, rd_ptr_r;
  logic [CNT_W-1:0] count_r;
  logic             do_push, do_pop;

  assign full      = (count_r == CNT_FULL);
  assign not_empty = (count_r != '0);
  assign do_push   = push && !full;
  assign do_pop    = pop && not_empty;
  assign pop_cmd   = slot_r[rd_ptr_r];

  // Storage
  always_ff @(posedge clk) begin
    if (do_push) begin
      slot_r[wr_ptr_r] <= push_cmd;
    end
  end

  // Pointers and fill count
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr_r <= (wr_ptr_r == PTR_LAST) ? '0 : wr_ptr_r + PTR_W'(1);
      end
      if (do_pop) begin
        rd_ptr_r <= (rd_ptr_r == PTR_LAST) ? '0 : rd_ptr_r + PTR_W'(1);
      end
      case ({do_push, do_pop})
        2'b10:   count_r <= count_r + CNT_W'(1);
        2'b01:   count_r <= count_r - CNT_W'(1);
        default: count_r <= count_r;
      endcase
    end
  end

endmodule

FILE: hw/rtl/pfd_back.sv
// Back end: value assembly, length tracking, verdict and output register.
module pfd_back
  import pfd_pkg::*;
(
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   cmd_valid,
  input  cmd_t                   cmd,
  output logic                   cmd_pop,
  output logic                   out_tvalid,
  input  logic                   out_tready,
  output logic [OUT_TDATA_W-1:0] out_tdata,
  output logic                   out_tuser,
  output logic                   out_tlast
);

  localparam logic [2:0] LAST_BYTE_POS = 3'(VALUE_BYTES - 1);

  logic [2:0]  byte_pos_r, byte_pos_nxt;
  logic [63:0] shift_r, shift_nxt;
  logic [31:0] seen_r, seen_nxt;
  logic        len_bad_r, len_bad_nxt;

  logic        emit;
  logic [1:0]  code;

  logic        out_valid_r;
  logic        value_valid_r;
  logic [63:0] value_bits_r;
  logic        frame_end_r;
  logic [1:0]  error_code_r;
  logic [31:0] sample_count_r;
  logic [31:0] value_count_r;

  // Take a request whenever the output register is free or draining
  assign cmd_pop = cmd_valid && (!out_valid_r || out_tready);

  // Value assembly for one payload byte
  always_comb begin
    byte_pos_nxt = byte_pos_r;
    shift_nxt    = shift_r;
    seen_nxt     = seen_r;
    len_bad_nxt  = len_bad_r;
    emit         = 1'b0;
    if (cmd.assemble && !len_bad_r) begin
      shift_nxt = {shift_r[55:0], cmd.data};
      if (byte_pos_r == LAST_BYTE_POS) begin
        byte_pos_nxt = '0;
        if (seen_r == cmd.value_cnt) begin
          len_bad_nxt = 1'b1;
        end else begin
          seen_nxt = seen_r + 32'd1;
          emit     = 1'b1;
        end
      end else begin
        byte_pos_nxt = byte_pos_r + 3'd1;
      end
    end
  end

  // Frame verdict, in priority order
  always_comb begin
    if (!cmd.hdr_done) begin
      code = ERR_SHORT_HDR;
    end else if (cmd.magic_bad) begin
      code = ERR_BAD_MAGIC;
    end else if (len_bad_nxt || byte_pos_nxt != '0 || seen_nxt != cmd.value_cnt) begin
      code = ERR_LENGTH;
    end else begin
      code = ERR_OK;
    end
  end

  // Assembly state, cleared at the end of each frame
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      byte_pos_r <= '0;
      seen_r     <= '0;
      len_bad_r  <= 1'b0;
    end else if (cmd_pop) begin
      if (cmd.last) begin
        byte_pos_r <= '0;
        seen_r     <= '0;
        len_bad_r  <= 1'b0;
      end else begin
        byte_pos_r <= byte_pos_nxt;
        seen_r     <= seen_nxt;
        len_bad_r  <= len_bad_nxt;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd_pop) begin
      shift_r <= shift_nxt;
    end
  end

  // Output register valid
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd_pop) begin
      out_valid_r <= emit || cmd.last;
    end else if (out_tready) begin
      out_valid_r <= 1'b0;
    end
  end

  // Output register payload
  always_ff @(posedge clk) begin
    if (cmd_pop && (emit || cmd.last)) begin
      value_valid_r  <= emit;
      value_bits_r   <= emit ? shift_nxt : 64'd0;
      frame_end_r    <= cmd.last;
      error_code_r   <= cmd.last ? code : ERR_OK;
      sample_count_r <= (cmd.last && cmd.hdr_done) ? cmd.sample_cnt : 32'd0;
      value_count_r  <= (cmd.last && cmd.hdr_done) ? cmd.value_cnt : 32'd0;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tuser  = value_valid_r;
  assign out_tlast  = frame_end_r;
  assign out_tdata  = {(OUT_TDATA_W - OUT_PAYLOAD_W)'(0), value_count_r, sample_count_r,
                       error_code_r, value_bits_r};

endmodule

FILE: hw/rtl/pfd_checker.sv
// Port-level checks for the payload frame decoder, bound to the top level.
module pfd_checker
  import pfd_pkg::*;
(
  input logic                   clk,
  input logic                   rst_n,
  input logic                   out_tvalid,
  input logic                   out_tready,
  input logic [OUT_TDATA_W-1:0] out_tdata,
  input logic                   out_tuser,
  input logic                   out_tlast
);

  // A stalled result holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata) &&
                                  $stable(out_tuser) && $stable(out_tlast))
    else $error("result changed while stalled");

  // Every result carries a value, a verdict or both
  a_not_empty: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> out_tuser || out_tlast)
    else $error("empty result");

  // No value means zero value bits
  a_value_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tuser |-> out_tdata[63:0] == 64'd0)
    else $error("value bits without a value");

  // Verdict fields are zero outside the frame end
  a_verdict_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tlast |-> out_tdata[129:64] == 66'd0)
    else $error("verdict fields outside frame end");

  // A short header reports no counts and no value
  a_short_counts: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tlast && out_tdata[65:64] == ERR_SHORT_HDR |->
      out_tdata[129:66] == 64'd0 && !out_tuser)
    else $error("counts or value reported on short header");

endmodule

bind payload_frame_decoder pfd_checker u_pfd_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata),
  .out_tuser  (out_tuser),
  .out_tlast  (out_tlast)
);
